[rtl/core/quad_fca_pkg.sv]
package quad_fca_pkg;

  // Field and bus widths
  localparam int COORD_W  = 24;
  localparam int IN_W     = 288;
  localparam int OUT_W    = 120;
  localparam int AREA_W   = 44;

  // Cross product datapath
  localparam int DIFF_W   = 25;
  localparam int PROD_W   = 50;
  localparam int CROSS_W  = 51;
  localparam int SQ_W     = 102;
  localparam int RAD_W    = 84;   // sum of squares with the /512 of the root folded in
  localparam int ROOT_W   = 42;

  // Weighting datapath
  localparam int SUM_W    = 26;
  localparam int SMAG_W   = 25;
  localparam int HALF_W   = 21;
  localparam int PP_W     = 46;
  localparam int MUL_W    = 67;
  localparam int TW       = 69;
  localparam int NMAG_W   = 68;
  localparam int NUM_W    = 71;
  localparam int DEN_W    = 46;
  localparam int QUO_W    = 25;

  // Stage counts
  localparam int CROSS_LAT = 6;
  localparam int SQRT_LAT  = ROOT_W;
  localparam int SUM_LAT   = CROSS_LAT + SQRT_LAT;
  localparam int DIV_LAT   = QUO_W;

  // Clamp limits of the centroid quotient
  localparam logic [QUO_W-1:0] QPOS_MAX = QUO_W'(24'h7FFFFF);
  localparam logic [QUO_W-1:0] QNEG_MAX = QUO_W'(24'h800000);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

endpackage

[rtl/core/quad_fca_cross.sv]
module quad_fca_cross import quad_fca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  point_t           o,
  input  point_t           a,
  input  point_t           b,
  output logic             out_valid,
  output logic [RAD_W-1:0] rad
);

  localparam int LO_W = 26;
  localparam int HI_W = CROSS_W - LO_W;

  logic [CROSS_LAT-1:0] vld;

  logic signed [DIFF_W-1:0] u [3];
  logic signed [DIFF_W-1:0] v [3];
  logic signed [PROD_W-1:0] pr [6];
  logic [CROSS_W-1:0]       cm [3];
  logic [2*HI_W-1:0]        hh [3];
  logic [HI_W+LO_W-1:0]     hl [3];
  logic [2*LO_W-1:0]        ll [3];
  logic [SQ_W-1:0]          sq [3];

  logic signed [CROSS_W-1:0] cc [3];
  logic [SQ_W-1:0]           ssum;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[CROSS_LAT-2:0], in_valid};
    end
  end

  // cross components and their magnitude
  always_comb begin
    cc[0] = CROSS_W'(pr[0]) - CROSS_W'(pr[1]);
    cc[1] = CROSS_W'(pr[2]) - CROSS_W'(pr[3]);
    cc[2] = CROSS_W'(pr[4]) - CROSS_W'(pr[5]);
    ssum  = sq[0] + sq[1] + sq[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // edge vectors from o
      u[0] <= DIFF_W'(a.x) - DIFF_W'(o.x);
      u[1] <= DIFF_W'(a.y) - DIFF_W'(o.y);
      u[2] <= DIFF_W'(a.z) - DIFF_W'(o.z);
      v[0] <= DIFF_W'(b.x) - DIFF_W'(o.x);
      v[1] <= DIFF_W'(b.y) - DIFF_W'(o.y);
      v[2] <= DIFF_W'(b.z) - DIFF_W'(o.z);
      // products
      pr[0] <= PROD_W'(u[1]) * PROD_W'(v[2]);
      pr[1] <= PROD_W'(u[2]) * PROD_W'(v[1]);
      pr[2] <= PROD_W'(u[2]) * PROD_W'(v[0]);
      pr[3] <= PROD_W'(u[0]) * PROD_W'(v[2]);
      pr[4] <= PROD_W'(u[0]) * PROD_W'(v[1]);
      pr[5] <= PROD_W'(u[1]) * PROD_W'(v[0]);
      for (int k = 0; k < 3; k++) begin
        cm[k] <= cc[k][CROSS_W-1] ? CROSS_W'(-cc[k]) : CROSS_W'(cc[k]);
        // square split into partial products
        hh[k] <= (2*HI_W)'(cm[k][CROSS_W-1:LO_W]) * (2*HI_W)'(cm[k][CROSS_W-1:LO_W]);
        hl[k] <= (HI_W+LO_W)'(cm[k][CROSS_W-1:LO_W]) * (HI_W+LO_W)'(cm[k][LO_W-1:0]);
        ll[k] <= (2*LO_W)'(cm[k][LO_W-1:0]) * (2*LO_W)'(cm[k][LO_W-1:0]);
        sq[k] <= (SQ_W'(hh[k]) << (2*LO_W)) + (SQ_W'(hl[k]) << (LO_W+1)) + SQ_W'(ll[k]);
      end
      // drop 18 bits: root shrinks by 512
      rad <= ssum[SQ_W-1:SQ_W-RAD_W];
    end
  end

  assign out_valid = vld[CROSS_LAT-1];

endmodule

[rtl/core/quad_fca_sqrt.sv]
module quad_fca_sqrt import quad_fca_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  output logic              out_valid,
  output logic [ROOT_W-1:0] root
);

  localparam int REM_W = ROOT_W + 2;

  logic [RAD_W-1:0]  rad_r  [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [ROOT_W-1:0] v_r;

  // one root bit per stage, restoring digit recurrence
  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [RAD_W-1:0]  rad_p;
    logic [REM_W-1:0]  rem_p;
    logic [ROOT_W-1:0] root_p;
    logic              v_p;
    logic [REM_W+1:0]  rem2;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (j == 0) begin : g_first
      assign rad_p  = rad;
      assign rem_p  = '0;
      assign root_p = '0;
      assign v_p    = in_valid;
    end else begin : g_next
      assign rad_p  = rad_r[j-1];
      assign rem_p  = rem_r[j-1];
      assign root_p = root_r[j-1];
      assign v_p    = v_r[j-1];
    end

    assign rem2  = {rem_p, rad_p[RAD_W-1 -: 2]};
    assign trial = (REM_W+2)'({root_p, 2'b01});
    assign ge    = rem2 >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[j]  <= rad_p << 2;
        rem_r[j]  <= ge ? REM_W'(rem2 - trial) : REM_W'(rem2);
        root_r[j] <= {root_p[ROOT_W-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign root      = root_r[ROOT_W-1];

endmodule

[rtl/core/quad_fca_div.sv]
module quad_fca_div import quad_fca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num [3],
  input  logic [DEN_W-1:0] den,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo [3]
);

  logic [NUM_W-1:0] rem_r [QUO_W][3];
  logic [QUO_W-1:0] q_r   [QUO_W][3];
  logic [DEN_W-1:0] den_r [QUO_W];
  logic [QUO_W-1:0] v_r;

  // one quotient bit per stage, three axes share the divisor
  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int SH = QUO_W - 1 - j;
    logic [NUM_W-1:0] rem_p [3];
    logic [QUO_W-1:0] q_p   [3];
    logic [DEN_W-1:0] den_p;
    logic             v_p;
    logic [NUM_W-1:0] dsh;

    if (j == 0) begin : g_first
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_p[k] = num[k];
          q_p[k]   = '0;
        end
      end
      assign den_p = den;
      assign v_p   = in_valid;
    end else begin : g_next
      always_comb begin
        for (int k = 0; k < 3; k++) begin
          rem_p[k] = rem_r[j-1][k];
          q_p[k]   = q_r[j-1][k];
        end
      end
      assign den_p = den_r[j-1];
      assign v_p   = v_r[j-1];
    end

    assign dsh = NUM_W'(den_p) << SH;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[j] <= 1'b0;
      end else if (en) begin
        v_r[j] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[j] <= den_p;
        for (int k = 0; k < 3; k++) begin
          if (rem_p[k] >= dsh) begin
            rem_r[j][k] <= rem_p[k] - dsh;
            q_r[j][k]   <= {q_p[k][QUO_W-2:0], 1'b1};
          end else begin
            rem_r[j][k] <= rem_p[k];
            q_r[j][k]   <= {q_p[k][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_valid = v_r[QUO_W-1];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quo[k] = q_r[QUO_W-1][k];
    end
  end

endmodule

[rtl/core/quad_face_centroid_area_core.sv]
// Pipeline stages in order: cross product, square root, weighting, divider and
// output register.
// Throughput: one face per cycle; the whole pipeline holds while the output
// register is full and not taken.
// Reset (rst, synchronous): clears the valid bits of every stage and the output.
module quad_face_centroid_area_core import quad_fca_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, p4_x, p4_y, p4_z
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // centre_x, centre_y, centre_z, area, 4 zero bits
  output logic [OUT_W-1:0] m_tdata,
  // valid_res
  output logic [0:0]       m_tuser
);

  function automatic coord_t axis(point_t p, int k);
    case (k)
      0:       return p.x;
      1:       return p.y;
      default: return p.z;
    endcase
  endfunction

  logic en;
  point_t p1, p2, p3, p4;

  // pipeline moves whenever the output register can take a result
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  assign p1 = {s_tdata[0*COORD_W +: COORD_W], s_tdata[1*COORD_W +: COORD_W],
               s_tdata[2*COORD_W +: COORD_W]};
  assign p2 = {s_tdata[3*COORD_W +: COORD_W], s_tdata[4*COORD_W +: COORD_W],
               s_tdata[5*COORD_W +: COORD_W]};
  assign p3 = {s_tdata[6*COORD_W +: COORD_W], s_tdata[7*COORD_W +: COORD_W],
               s_tdata[8*COORD_W +: COORD_W]};
  assign p4 = {s_tdata[9*COORD_W +: COORD_W], s_tdata[10*COORD_W +: COORD_W],
               s_tdata[11*COORD_W +: COORD_W]};

  // triangle areas
  logic             x1_valid, r_valid;
  logic [RAD_W-1:0] rad1, rad2;
  logic [ROOT_W-1:0] root1, root2;

  quad_fca_cross u_cross1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .o(p1), .a(p2), .b(p3), .out_valid(x1_valid), .rad(rad1)
  );

  quad_fca_cross u_cross2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .o(p1), .a(p4), .b(p3), .out_valid(), .rad(rad2)
  );

  quad_fca_sqrt u_sqrt1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(x1_valid),
    .rad(rad1), .out_valid(r_valid), .root(root1)
  );

  quad_fca_sqrt u_sqrt2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(x1_valid),
    .rad(rad2), .out_valid(), .root(root2)
  );

  // corner sums: entries 0..2 first triangle, 3..5 second, per axis
  logic signed [SUM_W-1:0] sum_in [6];
  logic signed [SUM_W-1:0] sd [SUM_LAT][6];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum_in[k]   = SUM_W'(axis(p1, k)) + SUM_W'(axis(p2, k)) + SUM_W'(axis(p3, k));
      sum_in[3+k] = SUM_W'(axis(p1, k)) + SUM_W'(axis(p4, k)) + SUM_W'(axis(p3, k));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= sum_in;
      for (int i = 1; i < SUM_LAT; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  // weighting stages
  logic [5:0]              wv;
  logic [ROOT_W-1:0]       w1_a1, w1_a2;
  logic [AREA_W-1:0]       w1_tot, w2_tot, w3_tot, w4_tot, w5_tot, w6_tot;
  logic [SMAG_W-1:0]       w1_mag [6];
  logic [5:0]              w1_neg, w2_neg, w3_neg;
  logic [DEN_W-1:0]        w2_d, w3_d, w4_d, w5_d;
  logic [PP_W-1:0]         w2_pl [6];
  logic [PP_W-1:0]         w2_ph [6];
  logic [MUL_W-1:0]        w3_m [6];
  logic [TW-1:0]           w4_t [3];
  logic [NMAG_W-1:0]       w5_n [3];
  logic [2:0]              w5_neg, w6_neg;
  logic [NUM_W-1:0]        w6_num [3];
  logic [DEN_W-1:0]        w6_den;

  always_ff @(posedge clk) begin
    if (rst) begin
      wv <= '0;
    end else if (en) begin
      wv <= {wv[4:0], r_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // areas, total, sum magnitudes (total stays below 2^43: no saturation)
      w1_a1  <= root1;
      w1_a2  <= root2;
      w1_tot <= AREA_W'(root1) + AREA_W'(root2);
      for (int k = 0; k < 6; k++) begin
        w1_neg[k] <= sd[SUM_LAT-1][k][SUM_W-1];
        w1_mag[k] <= sd[SUM_LAT-1][k][SUM_W-1] ? SMAG_W'(-sd[SUM_LAT-1][k])
                                                : SMAG_W'(sd[SUM_LAT-1][k]);
      end
      // 3*total and split products
      w2_d   <= DEN_W'(w1_tot) + (DEN_W'(w1_tot) << 1);
      w2_tot <= w1_tot;
      w2_neg <= w1_neg;
      for (int k = 0; k < 6; k++) begin
        w2_pl[k] <= PP_W'(w1_mag[k]) *
                    PP_W'(k < 3 ? w1_a1[HALF_W-1:0] : w1_a2[HALF_W-1:0]);
        w2_ph[k] <= PP_W'(w1_mag[k]) *
                    PP_W'(k < 3 ? w1_a1[ROOT_W-1:HALF_W] : w1_a2[ROOT_W-1:HALF_W]);
      end
      // join partial products
      w3_d   <= w2_d;
      w3_tot <= w2_tot;
      w3_neg <= w2_neg;
      for (int k = 0; k < 6; k++) begin
        w3_m[k] <= (MUL_W'(w2_ph[k]) << HALF_W) + MUL_W'(w2_pl[k]);
      end
      // signed sum of both weighted terms
      w4_d   <= w3_d;
      w4_tot <= w3_tot;
      for (int j = 0; j < 3; j++) begin
        w4_t[j] <= (w3_neg[j]   ? -TW'(w3_m[j])   : TW'(w3_m[j])) +
                   (w3_neg[3+j] ? -TW'(w3_m[3+j]) : TW'(w3_m[3+j]));
      end
      // magnitude and sign
      w5_d   <= w4_d;
      w5_tot <= w4_tot;
      for (int j = 0; j < 3; j++) begin
        w5_neg[j] <= w4_t[j][TW-1];
        w5_n[j]   <= w4_t[j][TW-1] ? NMAG_W'(-w4_t[j]) : NMAG_W'(w4_t[j]);
      end
      // rounding: (2n + d) / 2d
      w6_tot <= w5_tot;
      w6_neg <= w5_neg;
      w6_den <= w5_d << 1;
      for (int j = 0; j < 3; j++) begin
        w6_num[j] <= (NUM_W'(w5_n[j]) << 1) + NUM_W'(w5_d);
      end
    end
  end

  // divider and side data
  logic             d_valid;
  logic [QUO_W-1:0] quo [3];
  logic [AREA_W-1:0] dd_tot [DIV_LAT];
  logic [2:0]        dd_neg [DIV_LAT];

  quad_fca_div u_div (
    .clk(clk), .rst(rst), .en(en), .in_valid(wv[5]),
    .num(w6_num), .den(w6_den), .out_valid(d_valid), .quo(quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dd_tot[0] <= w6_tot;
      dd_neg[0] <= w6_neg;
      for (int i = 1; i < DIV_LAT; i++) begin
        dd_tot[i] <= dd_tot[i-1];
        dd_neg[i] <= dd_neg[i-1];
      end
    end
  end

  // clamp, sign and degenerate face
  logic [COORD_W-1:0] cen [3];
  logic [QUO_W-1:0]   qc;
  logic               nz;

  always_comb begin
    nz = dd_tot[DIV_LAT-1] != '0;
    qc = '0;
    for (int j = 0; j < 3; j++) begin
      if (dd_neg[DIV_LAT-1][j]) begin
        qc     = (quo[j] > QNEG_MAX) ? QNEG_MAX : quo[j];
        cen[j] = COORD_W'(-qc);
      end else begin
        qc     = (quo[j] > QPOS_MAX) ? QPOS_MAX : quo[j];
        cen[j] = COORD_W'(qc);
      end
      if (!nz) begin
        cen[j] = '0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'b0, dd_tot[DIV_LAT-1], cen[2], cen[1], cen[0]};
      m_tuser <= nz;
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import quad_fca_pkg::*;

  // one face prediction
  typedef struct {
    logic [23:0] cx;
    logic [23:0] cy;
    logic [23:0] cz;
    logic [43:0] area;
    logic        ok;
  } centroid_t;

  // floor(sqrt(s)) by bitwise restoring method
  function automatic longint unsigned isqrt(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] t;
    int b;
    r = 0;
    for (b = 52; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= s) r = t;
    end
    return r[63:0];
  endfunction

  // truncated Q.8 triangle area
  function automatic longint unsigned tri_area(longint o[3], longint a[3], longint b[3]);
    longint u[3];
    longint v[3];
    logic signed [127:0] c0;
    logic signed [127:0] c1;
    logic signed [127:0] c2;
    logic [127:0] s;
    for (int k = 0; k < 3; k++) begin
      u[k] = a[k] - o[k];
      v[k] = b[k] - o[k];
    end
    c0 = u[1] * v[2] - u[2] * v[1];
    c1 = u[2] * v[0] - u[0] * v[2];
    c2 = u[0] * v[1] - u[1] * v[0];
    s = c0 * c0 + c1 * c1 + c2 * c2;
    return isqrt(s) >> 9;
  endfunction

  // weighted centroid component, rounded half away from zero
  function automatic logic [23:0] weigh(longint s1, longint a1, longint s2, longint a2);
    logic signed [127:0] n;
    logic [127:0] m;
    logic [127:0] d;
    logic [127:0] q;
    n = 128'(s1) * 128'(a1) + 128'(s2) * 128'(a2);
    d = 3 * (a1 + a2);
    m = (n < 0) ? -n : n;
    q = (2 * m + d) / (2 * d);
    if (n < 0) begin
      if (q > 128'h800000) q = 128'h800000;
      return 24'(-q);
    end
    if (q > 128'h7FFFFF) q = 128'h7FFFFF;
    return q[23:0];
  endfunction

  function automatic centroid_t predict_centroid(logic [IN_W-1:0] face);
    longint p[4][3];
    longint a1;
    longint a2;
    centroid_t r;
    for (int i = 0; i < 4; i++)
      for (int k = 0; k < 3; k++)
        p[i][k] = longint'($signed(face[(i*3+k)*24 +: 24]));
    a1 = tri_area(p[0], p[1], p[2]);
    a2 = tri_area(p[0], p[3], p[2]);
    r = '{cx: 0, cy: 0, cz: 0, area: 0, ok: 0};
    if (a1 + a2 != 0) begin
      r.cx = weigh(p[0][0]+p[1][0]+p[2][0], a1, p[0][0]+p[3][0]+p[2][0], a2);
      r.cy = weigh(p[0][1]+p[1][1]+p[2][1], a1, p[0][1]+p[3][1]+p[2][1], a2);
      r.cz = weigh(p[0][2]+p[1][2]+p[2][2], a1, p[0][2]+p[3][2]+p[2][2], a2);
      r.area = 44'(a1 + a2);
      r.ok = 1;
    end
    return r;
  endfunction

  class centroid_board;
    centroid_t pending[$];
    int errors;

    function void note_face(logic [IN_W-1:0] face);
      pending = {pending, predict_centroid(face)};
    endfunction

    function void check_result(logic [OUT_W-1:0] data, logic ok);
      centroid_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[23:0] !== e.cx) begin
        $display("%0t: centre_x exp %h got %h", $time, e.cx, data[23:0]); errors++;
      end
      if (data[47:24] !== e.cy) begin
        $display("%0t: centre_y exp %h got %h", $time, e.cy, data[47:24]); errors++;
      end
      if (data[71:48] !== e.cz) begin
        $display("%0t: centre_z exp %h got %h", $time, e.cz, data[71:48]); errors++;
      end
      if (data[115:72] !== e.area) begin
        $display("%0t: area exp %h got %h", $time, e.area, data[115:72]); errors++;
      end
      if (ok !== e.ok) begin
        $display("%0t: valid_res exp %b got %b", $time, e.ok, ok); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic [0:0] m_tuser;

  centroid_board board;
  bit faces_done;
  bit hold_off;
  longint cycles;

  quad_face_centroid_area_core dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // short gaps mostly, a long one now and then
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [23:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 24'h800000;
      1: return 24'h7FFFFF;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic send_face(logic [IN_W-1:0] face);
    s_tvalid <= 1;
    s_tdata  <= face;
    do @(posedge clk); while (!s_tready);
    board.note_face(face);
  endtask

  task automatic send_idle();
    int g;
    g = gap_len();
    if (g == 0) return;
    s_tvalid <= 0;
    repeat (g) @(posedge clk);
  endtask

  function automatic logic [IN_W-1:0] make_quad(logic [23:0] c[12]);
    logic [IN_W-1:0] f;
    for (int i = 0; i < 12; i++) f[i*24 +: 24] = c[i];
    return f;
  endfunction

  // directed then random faces
  initial begin
    logic [23:0] c[12];
    logic [IN_W-1:0] f;
    board = new();
    s_tvalid = 0;
    s_tdata = '0;
    rst = 1;
    repeat (6) @(posedge clk);
    rst <= 0;
    // all zero: degenerate
    send_face('0);
    // all extremes
    send_face({IN_W{1'b1}});
    for (int i = 0; i < 12; i++) c[i] = 24'h800000;
    send_face(make_quad(c));
    for (int i = 0; i < 12; i++) c[i] = 24'h7FFFFF;
    send_face(make_quad(c));
    // unit square in xy, Q16.8
    c = '{0,0,0, 256,0,0, 256,256,0, 0,256,0};
    send_face(make_quad(c));
    // tiny face below one area step
    c = '{0,0,0, 1,0,0, 1,1,0, 0,1,0};
    send_face(make_quad(c));
    // huge opposite corners, negative centroid
    c = '{24'h800000,24'h800000,24'h800000, 24'h7FFFFF,24'h800000,24'h800000,
          24'h7FFFFF,24'h7FFFFF,24'h800000, 24'h800000,24'h7FFFFF,24'h7FFFFF};
    send_face(make_quad(c));
    // bow-tie, non-planar, collinear
    c = '{0,0,0, 512,512,0, 512,0,0, 0,512,256};
    send_face(make_quad(c));
    c = '{-300,-300,-300, 100,100,100, 300,300,300, -100,-100,-100};
    send_face(make_quad(c));
    for (int t = 0; t < 10; t++) begin
      for (int i = 0; i < 12; i++) c[i] = pick_coord();
      send_face(make_quad(c));
    end
    // random faces: mostly small coordinates, some full-range
    for (int n = 0; n < 1500; n++) begin
      send_idle();
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 12; i++) c[i] = pick_coord();
      end else begin
        for (int i = 0; i < 12; i++) c[i] = 24'($signed($urandom_range(0, 8191)) - 4096);
      end
      if ($urandom_range(0, 19) == 0) begin
        for (int i = 0; i < 3; i++) c[9+i] = c[i];
      end
      f = make_quad(c);
      send_face(f);
    end
    s_tvalid <= 0;
    faces_done = 1;
  end

  // long receiver hold-off so the pipeline backs up
  initial begin
    hold_off = 0;
    wait (!rst);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (400) @(posedge clk);
    hold_off = 0;
  end

  // receiver side
  initial begin
    int g;
    m_tready = 0;
    wait (!rst);
    forever begin
      g = gap_len();
      if (g != 0 || hold_off) begin
        m_tready <= 0;
        do @(posedge clk); while (hold_off || g-- > 1);
      end
      m_tready <= 1;
      @(posedge clk);
      if (m_tvalid) board.check_result(m_tdata, m_tuser[0]);
    end
  end

  // end of run and timeout
  initial begin
    cycles = 0;
    wait (faces_done);
    while (board.pending.size() != 0 && cycles < 400000) begin
      @(posedge clk);
      cycles++;
    end
    if (board.pending.size() != 0) begin
      $display("FAIL");
      $finish;
    end
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall cycle limit
  initial begin
    repeat (1000000) @(posedge clk);
    $display("FAIL");
    $finish;
  end

endmodule
